[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication: whenever ante holds, cons must hold.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

[src/fra_pkg.sv]
package fra_pkg;

  // operand and result field widths
  localparam int OperandWidth = 16;
  localparam int ProdWidth    = 2 * OperandWidth;
  localparam int SumWidth     = ProdWidth + 1;
  localparam int WholeWidth   = 32;
  localparam int FracNumWidth = 30;
  localparam int FracDenWidth = 31;

  // divider runs one quotient bit per cycle
  localparam int DivSteps     = WholeWidth;
  localparam int DivCntWidth  = $clog2(DivSteps + 1);

  // default depth of the queue between front and back
  localparam int QueueDepth   = 2;

  // operation codes
  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpSub = 2'd1;
  localparam logic [1:0] OpMul = 2'd2;
  localparam logic [1:0] OpDiv = 2'd3;

  typedef struct packed {
    logic [1:0]                     op;
    logic signed [OperandWidth-1:0] left_num;
    logic signed [OperandWidth-1:0] left_den;
    logic signed [OperandWidth-1:0] right_num;
    logic signed [OperandWidth-1:0] right_den;
  } fra_in_t;

  typedef struct packed {
    logic                    error;
    logic                    negative;
    logic                    is_whole;
    logic [WholeWidth-1:0]   whole_part;
    logic [FracNumWidth-1:0] frac_num;
    logic [FracDenWidth-1:0] frac_den;
  } fra_out_t;

  // classified request: magnitudes and sign of the unreduced fraction
  typedef struct packed {
    logic                    err;
    logic                    neg;
    logic [WholeWidth-1:0]   un;
    logic [FracDenWidth-1:0] ud;
  } fra_entry_t;

  typedef struct packed {
    logic                    start;
    logic [WholeWidth-1:0]   dividend0;
    logic [WholeWidth-1:0]   dividend1;
    logic [FracDenWidth-1:0] divisor;
  } fra_div_req_t;

  typedef struct packed {
    logic                    done;
    logic [WholeWidth-1:0]   quo0;
    logic [FracDenWidth-1:0] rem0;
    logic [WholeWidth-1:0]   quo1;
  } fra_div_resp_t;

endpackage

[src/fra_front.sv]
module fra_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  fra_pkg::fra_in_t    req_data,
  output logic                push_valid,
  input  logic                push_ready,
  output fra_pkg::fra_entry_t push_data
);
  import fra_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL0 = 3'd1;
  localparam logic [2:0] F_MUL1 = 3'd2;
  localparam logic [2:0] F_MUL2 = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  localparam logic signed [OperandWidth-1:0] OneOperand = OperandWidth'(1);

  logic [2:0]                     state;
  fra_in_t                        opnd;
  logic                           in_err;
  logic                           eq_den;
  logic signed [ProdWidth-1:0]    p0;
  logic signed [ProdWidth-1:0]    p1;
  logic signed [ProdWidth-1:0]    pd;

  logic                           addsub;
  logic signed [OperandWidth-1:0] ma;
  logic signed [OperandWidth-1:0] mb;
  logic signed [ProdWidth-1:0]    prod;
  logic signed [SumWidth-1:0]     num;
  logic [SumWidth-1:0]            unum;
  logic [ProdWidth-1:0]           uden;

  assign addsub = (opnd.op == OpAdd) || (opnd.op == OpSub);

  // operand select for the shared multiplier, one product per step
  always_comb begin
    ma = opnd.left_num;
    mb = OneOperand;
    case (state)
      F_MUL0: begin
        ma = opnd.left_num;
        if (addsub) begin
          mb = eq_den ? OneOperand : opnd.right_den;
        end else if (opnd.op == OpMul) begin
          mb = opnd.right_num;
        end else begin
          mb = opnd.right_den;
        end
      end
      F_MUL1: begin
        ma = opnd.right_num;
        mb = addsub ? (eq_den ? OneOperand : opnd.left_den) : '0;
      end
      F_MUL2: begin
        ma = opnd.left_den;
        if (addsub) begin
          mb = eq_den ? OneOperand : opnd.right_den;
        end else if (opnd.op == OpMul) begin
          mb = opnd.right_den;
        end else begin
          mb = opnd.right_num;
        end
      end
      default: begin
        ma = opnd.left_num;
        mb = OneOperand;
      end
    endcase
  end

  assign prod = ma * mb;

  // numerator sum and magnitudes
  always_comb begin
    if (opnd.op == OpSub) begin
      num = {p0[ProdWidth-1], p0} - {p1[ProdWidth-1], p1};
    end else begin
      num = {p0[ProdWidth-1], p0} + {p1[ProdWidth-1], p1};
    end
    unum = num[SumWidth-1] ? SumWidth'(-num) : SumWidth'(num);
    uden = pd[ProdWidth-1] ? ProdWidth'(-pd) : ProdWidth'(pd);
  end

  assign req_ready  = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);

  always_comb begin
    push_data.err = in_err || (pd == '0);
    push_data.neg = (num[SumWidth-1] ^ pd[ProdWidth-1]) && (num != '0);
    push_data.un  = unum[WholeWidth-1:0];
    push_data.ud  = uden[FracDenWidth-1:0];
  end

  // sequencer: capture, three products (skipped when a denominator is zero), push
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (req_valid) begin
            opnd   <= req_data;
            in_err <= (req_data.left_den == '0) || (req_data.right_den == '0);
            eq_den <= (req_data.left_den == req_data.right_den);
            if ((req_data.left_den == '0) || (req_data.right_den == '0)) begin
              state <= F_PUSH;
            end else begin
              state <= F_MUL0;
            end
          end
        end
        F_MUL0: begin
          p0    <= prod;
          state <= F_MUL1;
        end
        F_MUL1: begin
          p1    <= prod;
          state <= F_MUL2;
        end
        F_MUL2: begin
          pd    <= prod;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

[src/fra_queue.sv]
module fra_queue #(
  parameter int DEPTH = fra_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  fra_pkg::fra_entry_t push_data,
  output logic                head_valid,
  input  logic                pop,
  output fra_pkg::fra_entry_t head
);
  import fra_pkg::*;

  localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntWidth = $clog2(DEPTH + 1);

  fra_entry_t            slots [DEPTH];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [CntWidth-1:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != CntWidth'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntWidth'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntWidth'(1);
      end
    end
  end

endmodule

[src/fra_divider.sv]
module fra_divider (
  input  logic                   clk,
  input  logic                   rst,
  input  fra_pkg::fra_div_req_t  div_req,
  output fra_pkg::fra_div_resp_t div_resp
);
  import fra_pkg::*;

  logic [DivCntWidth-1:0]  cnt;
  logic                    done;
  logic [FracDenWidth-1:0] dvs;
  logic [WholeWidth-1:0]   quo0;
  logic [WholeWidth-1:0]   quo1;
  logic [FracDenWidth-1:0] rem0;
  logic [FracDenWidth-1:0] rem1;

  logic [WholeWidth-1:0]   t0;
  logic [WholeWidth-1:0]   t1;
  logic [WholeWidth-1:0]   d0;
  logic [WholeWidth-1:0]   d1;
  logic                    ge0;
  logic                    ge1;

  // one restoring step per lane, both lanes share the divisor
  always_comb begin
    t0  = {rem0, quo0[WholeWidth-1]};
    t1  = {rem1, quo1[WholeWidth-1]};
    ge0 = (t0 >= {1'b0, dvs});
    ge1 = (t1 >= {1'b0, dvs});
    d0  = t0 - {1'b0, dvs};
    d1  = t1 - {1'b0, dvs};
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == DivCntWidth'(1));
      if (div_req.start) begin
        cnt <= DivCntWidth'(DivSteps);
      end else if (cnt != '0) begin
        cnt <= cnt - DivCntWidth'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (div_req.start) begin
      dvs  <= div_req.divisor;
      quo0 <= div_req.dividend0;
      quo1 <= div_req.dividend1;
      rem0 <= '0;
      rem1 <= '0;
    end else if (cnt != '0) begin
      rem0 <= ge0 ? d0[FracDenWidth-1:0] : t0[FracDenWidth-1:0];
      rem1 <= ge1 ? d1[FracDenWidth-1:0] : t1[FracDenWidth-1:0];
      quo0 <= {quo0[WholeWidth-2:0], ge0};
      quo1 <= {quo1[WholeWidth-2:0], ge1};
    end
  end

  always_comb begin
    div_resp.done = done;
    div_resp.quo0 = quo0;
    div_resp.rem0 = rem0;
    div_resp.quo1 = quo1;
  end

endmodule

[src/fra_back.sv]
module fra_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  fra_pkg::fra_entry_t    head,
  output logic                   pop,
  output fra_pkg::fra_div_req_t  div_req,
  input  fra_pkg::fra_div_resp_t div_resp,
  output logic                   res_valid,
  input  logic                   res_ready,
  output fra_pkg::fra_out_t      res_data
);
  import fra_pkg::*;

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_START1 = 3'd1;
  localparam logic [2:0] B_DIV1   = 3'd2;
  localparam logic [2:0] B_GCD    = 3'd3;
  localparam logic [2:0] B_START2 = 3'd4;
  localparam logic [2:0] B_DIV2   = 3'd5;
  localparam logic [2:0] B_DONE   = 3'd6;

  localparam int ShiftWidth = $clog2(FracDenWidth);

  logic [2:0]              state;
  logic                    neg;
  logic [WholeWidth-1:0]   un;
  logic [FracDenWidth-1:0] ud;
  logic [WholeWidth-1:0]   quot;
  logic [FracNumWidth-1:0] rmd;
  logic [FracDenWidth-1:0] gu;
  logic [FracDenWidth-1:0] gv;
  logic [ShiftWidth-1:0]   gk;
  logic [FracDenWidth-1:0] gcd;
  fra_out_t                result;

  assign pop = (state == B_IDLE) && head_valid;

  // divider requests: first un / ud, then remainder and ud by the gcd
  always_comb begin
    div_req.start     = (state == B_START1) || (state == B_START2);
    div_req.dividend0 = (state == B_START1) ? un : WholeWidth'(rmd);
    div_req.dividend1 = WholeWidth'(ud);
    div_req.divisor   = (state == B_START1) ? ud : gcd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && (state != B_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (head_valid) begin
            un  <= head.un;
            ud  <= head.ud;
            neg <= head.neg;
            if (head.err) begin
              result.error      <= 1'b1;
              result.negative   <= 1'b0;
              result.is_whole   <= 1'b0;
              result.whole_part <= '0;
              result.frac_num   <= '0;
              result.frac_den   <= '0;
              state             <= B_DONE;
            end else begin
              state <= B_START1;
            end
          end
        end
        B_START1: state <= B_DIV1;
        // whole part and remainder
        B_DIV1: begin
          if (div_resp.done) begin
            quot <= div_resp.quo0;
            rmd  <= div_resp.rem0[FracNumWidth-1:0];
            if (div_resp.rem0 == '0) begin
              result.error      <= 1'b0;
              result.negative   <= neg;
              result.is_whole   <= 1'b1;
              result.whole_part <= div_resp.quo0;
              result.frac_num   <= '0;
              result.frac_den   <= '0;
              state             <= B_DONE;
            end else begin
              gu    <= ud;
              gv    <= div_resp.rem0;
              gk    <= '0;
              state <= B_GCD;
            end
          end
        end
        // binary gcd of ud and the remainder, one step a cycle
        B_GCD: begin
          if (gu == gv) begin
            gcd   <= gu << gk;
            state <= B_START2;
          end else if (!gu[0] && !gv[0]) begin
            gu <= gu >> 1;
            gv <= gv >> 1;
            gk <= gk + ShiftWidth'(1);
          end else if (!gu[0]) begin
            gu <= gu >> 1;
          end else if (!gv[0]) begin
            gv <= gv >> 1;
          end else if (gu > gv) begin
            gu <= (gu - gv) >> 1;
          end else begin
            gv <= (gv - gu) >> 1;
          end
        end
        B_START2: state <= B_DIV2;
        // reduced numerator and denominator
        B_DIV2: begin
          if (div_resp.done) begin
            result.error      <= 1'b0;
            result.negative   <= neg;
            result.is_whole   <= 1'b0;
            result.whole_part <= quot;
            result.frac_num   <= div_resp.quo0[FracNumWidth-1:0];
            result.frac_den   <= div_resp.quo1[FracDenWidth-1:0];
            state             <= B_DONE;
          end
        end
        // hand over to the output register
        B_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            res_data  <= result;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[src/fraction_arith_reduce.sv]
// Channel   Direction  Handshake               Payload
// request   in         req_valid / req_ready   req_data (fra_in_t)
// result    out        res_valid / res_ready   res_data (fra_out_t)
//
// Front: one request at a time: capture, three products on one 16x16
// multiplier, push; an input denominator of zero skips the products. Back:
// an error goes straight to done, a whole result takes one divider run, a
// reduced fraction two 32-step divider runs with binary gcd steps between.
// Sync reset clears control state only. A stalled result holds the back
// in its done state while the queue lets the front take requests until full.
`include "assert_macros.svh"

module fraction_arith_reduce #(
  parameter int QUEUE_DEPTH = fra_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  fra_pkg::fra_in_t  req_data,
  output logic              res_valid,
  input  logic              res_ready,
  output fra_pkg::fra_out_t res_data
);
  import fra_pkg::*;

  logic          push_valid;
  logic          push_ready;
  fra_entry_t    push_data;
  logic          head_valid;
  logic          pop;
  fra_entry_t    head;
  fra_div_req_t  div_req;
  fra_div_resp_t div_resp;

  fra_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_data   (req_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  fra_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  fra_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .div_req  (div_req),
    .div_resp (div_resp)
  );

  fra_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .div_req    (div_req),
    .div_resp   (div_resp),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

  // front takes one request at a time
  `ASSERT_NEXT(a_front_busy, req_valid && req_ready, !req_ready, "front took back-to-back requests")
  // a reduced fraction is proper and nonzero
  `ASSERT_IMPL(a_proper_frac, res_valid && !res_data.error && !res_data.is_whole, (res_data.frac_num != '0) && ({1'b0, res_data.frac_num} < res_data.frac_den), "fraction not proper")
  // whole and error results carry no fraction
  `ASSERT_IMPL(a_whole_clean, res_valid && (res_data.is_whole || res_data.error), (res_data.frac_num == '0) && (res_data.frac_den == '0), "fraction fields set on whole result")
  // divider start pulses never run back to back
  `ASSERT_NEXT(a_div_start, div_req.start, !div_req.start, "divider restarted")

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
  import fra_pkg::*;

  localparam int NumRandom  = 1150;
  localparam int IdleLimit  = 6000;   // cycles with no handshake before giving up
  localparam int HoldCycles = 900;    // long result back-pressure window
  localparam int TailCycles = 200;    // wait after the expected results have drained

  // one row of the directed table
  typedef struct {
    fra_in_t  stim;
    bit       known;
    fra_out_t res;
  } row_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  fra_in_t  req_data;
  logic     res_valid;
  logic     res_ready;
  fra_out_t res_data;

  // typed-in expectation that travels with the request being offered
  bit       cur_known;
  fra_out_t cur_res;

  fra_out_t expected_results[$];
  row_t     directed[$];
  bit       no_idle;
  bit       hold_done;
  int       n_req, n_res, n_bad;
  int       n_err, n_whole, n_frac, n_neg;
  int       idle_cycles;

  fraction_arith_reduce dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  always #4 clk = ~clk;

  // exact rational result, reduced to sign plus mixed number
  function automatic fra_out_t reduce_fraction(fra_in_t r);
    longint a, b, x, y, num, den;
    longint unsigned un, ud, p, q, t;
    fra_out_t o;
    o = '0;
    a = $signed(r.left_num);
    b = $signed(r.left_den);
    x = $signed(r.right_num);
    y = $signed(r.right_den);
    if (b == 0 || y == 0) begin
      o.error = 1'b1;
      return o;
    end
    case (r.op)
      OpAdd: begin
        if (b == y) begin
          num = a + x;
          den = b;
        end else begin
          num = a * y + x * b;
          den = b * y;
        end
      end
      OpSub: begin
        if (b == y) begin
          num = a - x;
          den = b;
        end else begin
          num = a * y - x * b;
          den = b * y;
        end
      end
      OpMul: begin
        num = a * x;
        den = b * y;
      end
      default: begin
        num = a * y;
        den = b * x;
      end
    endcase
    if (den == 0) begin
      o.error = 1'b1;
      return o;
    end
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    o.negative = ((num < 0) != (den < 0)) && (num != 0);
    if (un % ud == 0) begin
      t = un / ud;
      o.is_whole   = 1'b1;
      o.whole_part = t[31:0];
      return o;
    end
    // Euclid on the magnitudes
    p = un;
    q = ud;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    un = un / p;
    ud = ud / p;
    t = un / ud;
    o.whole_part = t[31:0];
    t = un % ud;
    o.frac_num = t[29:0];
    o.frac_den = ud[30:0];
    return o;
  endfunction

  function automatic fra_in_t mk(logic [1:0] op, int a, int b, int x, int y);
    fra_in_t r;
    r.op        = op;
    r.left_num  = a[15:0];
    r.left_den  = b[15:0];
    r.right_num = x[15:0];
    r.right_den = y[15:0];
    return r;
  endfunction

  function automatic fra_out_t res(bit err, bit neg, bit whole, int unsigned wp,
                                   int unsigned fn, int unsigned fd);
    fra_out_t o;
    o.error      = err;
    o.negative   = neg;
    o.is_whole   = whole;
    o.whole_part = wp;
    o.frac_num   = fn[29:0];
    o.frac_den   = fd[30:0];
    return o;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic int edge_value();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32767;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int small_num();
    return int'($urandom_range(0, 40)) - 20;
  endfunction

  function automatic int small_den();
    int d;
    d = int'($urandom_range(1, 12));
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  // random request: mostly valid fractions, some extremes and error cases
  function automatic fra_in_t random_request();
    int k, d;
    logic [1:0] op;
    op = 2'($urandom_range(0, 3));
    k = $urandom_range(0, 99);
    if (k < 35) begin
      return mk(op, $urandom, $urandom, $urandom, $urandom);
    end else if (k < 65) begin
      return mk(op, small_num(), small_den(), small_num(), small_den());
    end else if (k < 80) begin
      // shared denominator path
      d = $urandom_range(0, 1) ? small_den() : int'($urandom_range(1, 65535));
      return mk(op, $urandom_range(0, 1) ? small_num() : int'($urandom), d,
                $urandom_range(0, 1) ? small_num() : int'($urandom), d);
    end else if (k < 90) begin
      return mk(op, edge_value(), edge_value(), edge_value(), edge_value());
    end else begin
      // zero denominators, or a divide by a zero fraction
      case ($urandom_range(0, 2))
        0: return mk(op, $urandom, 0, $urandom, $urandom);
        1: return mk(op, $urandom, $urandom, $urandom, 0);
        default: return mk(OpDiv, $urandom, small_den(), 0, $urandom_range(1, 65535));
      endcase
    end
  endfunction

  task automatic report_bad(string what, fra_out_t e, fra_out_t g);
    n_bad++;
    if (n_bad <= 10)
      $display("%0t %s: exp err=%0b neg=%0b whole=%0b wp=%0d fn=%0d fd=%0d | got err=%0b neg=%0b whole=%0b wp=%0d fn=%0d fd=%0d",
               $realtime, what, e.error, e.negative, e.is_whole, e.whole_part, e.frac_num,
               e.frac_den, g.error, g.negative, g.is_whole, g.whole_part, g.frac_num,
               g.frac_den);
  endtask

  // offer one request after a random gap, hold it until taken
  task automatic send(fra_in_t item, bit known, fra_out_t known_res);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req_data  <= item;
    cur_known <= known;
    cur_res   <= known_res;
    do @(posedge clk); while (!req_ready);
  endtask

  // request capture and result check
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        expected_results.push_back(cur_known ? cur_res : reduce_fraction(req_data));
        n_req++;
      end
      if (res_valid && res_ready) begin
        n_res++;
        if (res_data.error) n_err++;
        else if (res_data.is_whole) n_whole++;
        else n_frac++;
        if (res_data.negative) n_neg++;
        if (expected_results.size() == 0) begin
          report_bad("unexpected result", '0, res_data);
        end else begin
          fra_out_t e;
          e = expected_results.pop_front();
          if (e.error != res_data.error || e.negative != res_data.negative ||
              e.is_whole != res_data.is_whole || e.whole_part != res_data.whole_part ||
              e.frac_num != res_data.frac_num || e.frac_den != res_data.frac_den)
            report_bad("mismatch", e, res_data);
        end
      end
    end
  end

  // watchdog: no handshake for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog: no progress for %0d cycles, %0d results pending",
                 IdleLimit, expected_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    res_ready = 1'b0;
    hold_done = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!hold_done && n_req >= 300) begin
        // long hold-off so the queue fills and the input stalls
        hold_done = 1'b1;
        repeat (HoldCycles) begin
          @(negedge clk);
          res_ready <= 1'b0;
        end
      end else if (no_idle) begin
        @(negedge clk);
        res_ready <= 1'b1;
      end else begin
        stall = pick_gap();
        repeat (stall) begin
          @(negedge clk);
          res_ready <= 1'b0;
        end
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk);
          res_ready <= 1'b1;
        end
      end
    end
  end

  // main sequence
  initial begin
    rst         = 1'b1;
    req_valid   = 1'b0;
    req_data    = '0;
    cur_known   = 1'b0;
    cur_res     = '0;
    no_idle     = 1'b0;
    idle_cycles = 0;

    // errors, zero, plain whole and fraction results with known answers
    directed.push_back('{mk(OpAdd, 1, 0, 1, 1), 1, res(1, 0, 0, 0, 0, 0)});
    directed.push_back('{mk(OpDiv, 5, 3, 2, 0), 1, res(1, 0, 0, 0, 0, 0)});
    directed.push_back('{mk(OpDiv, 5, 3, 0, 7), 1, res(1, 0, 0, 0, 0, 0)});
    directed.push_back('{mk(OpMul, 0, 0, 0, 0), 1, res(1, 0, 0, 0, 0, 0)});
    directed.push_back('{mk(OpSub, 3, 4, 3, 4), 1, res(0, 0, 1, 0, 0, 0)});
    directed.push_back('{mk(OpAdd, 1, 1, 1, 1), 1, res(0, 0, 1, 2, 0, 0)});
    directed.push_back('{mk(OpMul, -32768, 1, -32768, 1), 1,
                         res(0, 0, 1, 32'h4000_0000, 0, 0)});
    directed.push_back('{mk(OpMul, 1, 2, 1, 3), 1, res(0, 0, 0, 0, 1, 6)});
    directed.push_back('{mk(OpAdd, 0, -5, 0, 3), 1, res(0, 0, 1, 0, 0, 0)});
    directed.push_back('{mk(OpDiv, 7, 1, -2, 1), 1, res(0, 1, 0, 3, 1, 2)});
    // extremes and sign mixes, checked by the predictor
    directed.push_back('{mk(OpAdd, 32767, 32767, 32767, -32768), 0, '0});
    directed.push_back('{mk(OpSub, -32768, -32768, 32767, 1), 0, '0});
    directed.push_back('{mk(OpMul, -32768, 32767, 32767, -32768), 0, '0});
    directed.push_back('{mk(OpDiv, -32768, 1, 1, -32768), 0, '0});
    directed.push_back('{mk(OpDiv, 32767, -1, -32768, 32767), 0, '0});
    directed.push_back('{mk(OpAdd, -7, 3, -7, 3), 0, '0});
    directed.push_back('{mk(OpSub, 5, -6, 1, 4), 0, '0});
    directed.push_back('{mk(OpMul, -3, 8, 5, -7), 0, '0});
    directed.push_back('{mk(OpDiv, 22, 7, -11, 14), 0, '0});
    directed.push_back('{mk(OpAdd, -32768, -32768, -32768, -32768), 0, '0});
    directed.push_back('{mk(OpSub, 1, 32767, 1, -32768), 0, '0});
    directed.push_back('{mk(OpAdd, 100, 7, 3, 7), 0, '0});
    directed.push_back('{mk(OpMul, 0, -32768, 32767, 32767), 0, '0});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send(directed[i].stim, directed[i].known, directed[i].res);

    for (int i = 0; i < NumRandom; i++) begin
      // every fourth block of 128 runs with no idling on either side
      no_idle = ((i / 128) % 4) == 2;
      send(random_request(), 1'b0, '0);
    end
    no_idle = 1'b0;
    @(negedge clk);
    req_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (expected_results.size() != 0)
      report_bad("result never arrived", expected_results[0], '0);

    $display("Covered %0d requests, %0d results: %0d errors, %0d whole, %0d reduced fractions",
             n_req, n_res, n_err, n_whole, n_frac);
    $display("%0d negative results, %0d bad results", n_neg, n_bad);
    if (n_bad == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
